>>> design/lcfc_pkg.sv
// Package for the LED command frame checker: frame constants, command and
// acknowledge codes, and the job record passed from front to back.
// No dependencies.
package lcfc_pkg;

    localparam int HEAD_LEN = 5;
    localparam int HEAD_IW  = $clog2(HEAD_LEN);

    localparam logic [7:0] MARK_BYTE           = 8'hFF;
    localparam logic [7:0] CODE_NOT_SUPPORTED  = 8'hA0;
    localparam logic [7:0] CODE_CHECKSUM       = 8'hE0;
    localparam logic [7:0] CODE_NOT_UNDERSTOOD = 8'hC0;

    localparam logic [15:0] CMD_LED_ON  = 16'h0001;
    localparam logic [15:0] CMD_LED_OFF = 16'h0002;
    localparam logic [15:0] CMD_LCD     = 16'h0003;
    localparam logic [15:0] CMD_BUTTON  = 16'h0004;

    localparam logic [7:0] LED_LEN   = 8'h01;
    localparam int         LED_COUNT = 4;

    typedef logic [HEAD_LEN-1:0][7:0] head_t;

    // One queued job: either a five byte acknowledge or one LED update.
    typedef struct packed {
        logic                 is_ack;
        head_t                head;
        logic [LED_COUNT-1:0] led;
    } job_t;

endpackage

>>> design/lcfc_front.sv
// Front part: takes frame bytes, keeps sum, count and head, and classifies
// each frame end into a job. Depends on lcfc_pkg.
module lcfc_front #(
    parameter int FRAME_MAX = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    input  logic          end_of_frame,
    output logic          job_push,
    output lcfc_pkg::job_t job
);
    import lcfc_pkg::*;

    localparam int CW = $clog2(FRAME_MAX + 1);

    logic [7:0]           sum_reg, sum_next;
    logic [7:0]           prev_reg, prev_next;
    logic [CW-1:0]        count_reg, count_next;
    head_t                head_reg, head_next;
    logic [LED_COUNT-1:0] led_reg, led_next;

    head_t                head_w;
    head_t                head_ack;
    logic [7:0]           sum_w;
    logic [CW-1:0]        count_inc;
    logic                 frame_end;
    logic [7:0]           code;
    logic                 do_ack;
    logic                 do_led;
    logic [LED_COUNT-1:0] led_upd;
    logic [15:0]          cmd;

    always_comb
    begin
        head_w = head_reg;
        if (count_reg < CW'(HEAD_LEN))
        begin
            head_w[count_reg[HEAD_IW-1:0]] = rx_byte;
        end
        sum_w     = (count_reg >= CW'(2)) ? sum_reg + prev_reg : sum_reg;
        count_inc = count_reg + CW'(1);
        frame_end = end_of_frame || (count_inc == CW'(FRAME_MAX));
        cmd       = {head_w[1], head_w[2]};

        code    = CODE_CHECKSUM;
        do_ack  = 1'b0;
        do_led  = 1'b0;
        led_upd = led_reg;
        if (rx_byte != sum_w)
        begin
            do_ack = 1'b1;
            code   = CODE_CHECKSUM;
        end
        else if (head_w[0] != MARK_BYTE)
        begin
            do_ack = 1'b1;
            code   = CODE_NOT_SUPPORTED;
        end
        else
        begin
            unique case (cmd) inside
                CMD_LED_ON, CMD_LED_OFF:
                begin
                    if (head_w[3] == LED_LEN)
                    begin
                        do_led = 1'b1;
                        if (head_w[4] < 8'(LED_COUNT))
                        begin
                            led_upd[head_w[4][1:0]] = (cmd == CMD_LED_ON);
                        end
                    end
                end
                CMD_LCD, CMD_BUTTON:
                begin
                    // no action: drop the frame
                end
                default:
                begin
                    do_ack = 1'b1;
                    code   = CODE_NOT_UNDERSTOOD;
                end
            endcase
        end

        head_ack    = head_w;
        head_ack[0] = MARK_BYTE;
        head_ack[1] = head_w[1] | code;
        head_ack[3] = 8'h00;
        head_ack[4] = head_ack[1] + head_ack[2];

        sum_next   = sum_reg;
        prev_next  = prev_reg;
        count_next = count_reg;
        head_next  = head_reg;
        led_next   = led_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                sum_next   = 8'h00;
                prev_next  = 8'h00;
                count_next = '0;
                head_next  = do_ack ? head_ack : head_w;
                led_next   = do_led ? led_upd : led_reg;
            end
            else
            begin
                sum_next   = sum_w;
                prev_next  = rx_byte;
                count_next = count_inc;
                head_next  = head_w;
            end
        end

        job_push   = accept && frame_end && (do_ack || do_led);
        job.is_ack = do_ack;
        job.head   = head_ack;
        job.led    = led_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= 8'h00;
            prev_reg  <= 8'h00;
            count_reg <= '0;
            head_reg  <= '0;
            led_reg   <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            prev_reg  <= prev_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            led_reg   <= led_next;
        end
    end

endmodule

>>> design/lcfc_job_fifo.sv
// Two-entry job queue between front and back.
// Depends on lcfc_pkg.
module lcfc_job_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lcfc_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           valid,
    output lcfc_pkg::job_t head_job
);
    import lcfc_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> design/lcfc_back.sv
// Back part: takes jobs from the queue and hands out their results one per
// pop. Depends on lcfc_pkg.
module lcfc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  lcfc_pkg::job_t job,
    output logic           job_pop,
    input  logic           pop,
    output logic           empty,
    output logic           out_kind,
    output logic [7:0]     tx_byte,
    output logic           run_last,
    output logic [3:0]     led_lit
);
    import lcfc_pkg::*;

    logic               active_reg, active_next;
    logic [HEAD_IW-1:0] idx_reg, idx_next;
    job_t               job_reg, job_next;
    logic               last;
    logic               take;

    assign last     = !job_reg.is_ack || (idx_reg == HEAD_IW'(HEAD_LEN - 1));
    assign take     = active_reg && pop;
    assign job_pop  = job_valid && (!active_reg || (take && last));
    assign empty    = !active_reg;
    assign out_kind = !job_reg.is_ack;
    assign tx_byte  = job_reg.is_ack ? job_reg.head[idx_reg] : 8'h00;
    assign run_last = last;
    assign led_lit  = job_reg.is_ack ? 4'h0 : job_reg.led;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        job_next    = job_reg;
        if (job_pop)
        begin
            active_next = 1'b1;
            idx_next    = '0;
            job_next    = job;
        end
        else if (take)
        begin
            if (last)
            begin
                active_next = 1'b0;
                idx_next    = '0;
            end
            else
            begin
                idx_next = idx_reg + HEAD_IW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

>>> design/led_command_frame_checker.sv
// Top level of the LED command frame checker: front, job queue and back.
// Depends on lcfc_pkg, lcfc_front, lcfc_job_fifo and lcfc_back.

// Takes one received byte per clock cycle while full is low. Each frame
// closes on a byte flagged end_of_frame or on its FRAME_MAX-th byte, and at
// that byte the front decides what the frame asks for: a five byte
// acknowledge (checksum error, not supported, not understood), one LED state
// update, or nothing. That decision is queued in a two-entry job queue and
// the back hands the results out, one per pop, so a byte can be taken in
// the same cycle as a result leaves. full rises only when two finished
// jobs wait in the queue; the queue depth and the drain rate of the result
// side (one result per cycle while pop is high) set how long a burst of short
// frames can run without a stall. There is no clearing pass after reset.
module led_command_frame_checker #(
    parameter int FRAME_MAX = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    input  logic       end_of_frame,
    output logic       empty,
    input  logic       pop,
    output logic       out_kind,
    output logic [7:0] tx_byte,
    output logic       run_last,
    output logic [3:0] led_lit
);
    import lcfc_pkg::*;

    logic accept;
    logic job_push;
    job_t front_job;
    logic fifo_full;
    logic fifo_valid;
    job_t fifo_job;
    logic fifo_pop;

    // Hold off input whenever the queue cannot take a job: any byte might
    // close a frame.
    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    lcfc_front #(
        .FRAME_MAX (FRAME_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .rx_byte      (rx_byte),
        .end_of_frame (end_of_frame),
        .job_push     (job_push),
        .job          (front_job)
    );

    // Decouple the byte side from the result side.
    lcfc_job_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (front_job),
        .pop      (fifo_pop),
        .full     (fifo_full),
        .valid    (fifo_valid),
        .head_job (fifo_job)
    );

    // Advance through the current job, one result per accepted pop.
    lcfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (fifo_valid),
        .job       (fifo_job),
        .job_pop   (fifo_pop),
        .pop       (pop),
        .empty     (empty),
        .out_kind  (out_kind),
        .tx_byte   (tx_byte),
        .run_last  (run_last),
        .led_lit   (led_lit)
    );

endmodule

>>> design/lcfc_checker.sv
// Port-level checks for the LED command frame checker, bound to the top level.
// Depends on led_command_frame_checker.
module lcfc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       out_kind,
    input logic [7:0] tx_byte,
    input logic       run_last,
    input logic [3:0] led_lit
);

    // hold a waiting result until it is popped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable({out_kind, tx_byte, run_last, led_lit})))
        else $error("waiting result changed or vanished");

    // an acknowledge run continues without a gap
    a_ack_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !run_last) |=> (!empty && !out_kind))
        else $error("acknowledge run broken");

    // an LED update is a run of one with no byte
    a_led_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind) |-> (run_last && (tx_byte == 8'h00)))
        else $error("malformed LED update");

    // acknowledge bytes carry no LED state
    a_ack_no_led: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_kind) |-> (led_lit == 4'h0))
        else $error("acknowledge byte with LED state");

endmodule

bind led_command_frame_checker lcfc_checker u_lcfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_kind (out_kind),
    .tx_byte  (tx_byte),
    .run_last (run_last),
    .led_lit  (led_lit)
);

>>> sim/led_command_frame_checker_tb.sv
// Self-checking testbench for led_command_frame_checker: frames of bytes go in,
// and acknowledge and LED replies are checked against an in-bench predictor.
// Depends on lcfc_pkg and the led_command_frame_checker RTL.
module led_command_frame_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcfc_pkg::*;

    localparam int FRAME_MAX    = 256;
    localparam int RANDOM_ITEMS = 180;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE_TIME  = 20;
    localparam int REPORT_LIMIT = 10;

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_LED = 1'b1;

    typedef logic [7:0] byte_q_t[$];

    // One reply as seen on the result ports
    typedef struct packed {
        logic       kind;
        logic [7:0] tx;
        logic       last;
        logic [3:0] leds;
    } reply_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] rx_byte;
    logic       end_of_frame;
    logic       empty;
    logic       pop;
    logic       out_kind;
    logic [7:0] tx_byte;
    logic       run_last;
    logic [3:0] led_lit;

    // Predictor state: a private copy of the frame tracker and LED register
    logic [7:0] byte_sum;
    logic [7:0] last_byte;
    logic [8:0] seen_count;
    logic [7:0] head_copy [HEAD_LEN];
    logic [3:0] led_copy;

    reply_t awaited_replies[$];
    int     reply_errors;
    int     requests_taken;
    logic   sender_steady;

    led_command_frame_checker #(
        .FRAME_MAX(FRAME_MAX)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .rx_byte(rx_byte),
        .end_of_frame(end_of_frame),
        .empty(empty),
        .pop(pop),
        .out_kind(out_kind),
        .tx_byte(tx_byte),
        .run_last(run_last),
        .led_lit(led_lit)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run
    initial
    begin
        #1ms;
        $display("** led_command_frame_checker: FAILED **");
        $finish;
    end

    // Idle length: mostly none, often a short one, now and then a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------

    task automatic clear_model();
        byte_sum   = '0;
        last_byte  = '0;
        seen_count = '0;
        led_copy   = '0;
        foreach (head_copy[k])
            head_copy[k] = '0;
    endtask

    // Build the acknowledge in the stored head, then queue its five bytes.
    // The head keeps these bytes, so a later short frame sees them.
    task automatic queue_ack(input logic [7:0] code);
        reply_t r;
        head_copy[0] = MARK_BYTE;
        head_copy[1] = head_copy[1] | code;
        head_copy[3] = 8'h00;
        head_copy[4] = head_copy[1] + head_copy[2] + head_copy[3];
        for (int k = 0; k < HEAD_LEN; k++)
        begin
            r.kind = KIND_ACK;
            r.tx   = head_copy[k];
            r.last = (k == HEAD_LEN - 1);
            r.leds = 4'h0;
            awaited_replies.push_back(r);
        end
    endtask

    // Decode a frame that passed the checksum and mark checks
    task automatic decode_command();
        logic [15:0] cmd;
        logic [7:0]  led_no;
        reply_t      r;
        cmd    = {head_copy[1], head_copy[2]};
        led_no = head_copy[4];
        if (cmd == CMD_LED_ON || cmd == CMD_LED_OFF)
        begin
            // Wrong length: drop the command silently
            if (head_copy[3] != LED_LEN)
                return;
            // An LED number out of range leaves the state alone but still reports it
            if (led_no < LED_COUNT)
                led_copy[led_no[1:0]] = (cmd == CMD_LED_ON);
            r.kind = KIND_LED;
            r.tx   = 8'h00;
            r.last = 1'b1;
            r.leds = led_copy;
            awaited_replies.push_back(r);
        end
        else if (cmd != CMD_LCD && cmd != CMD_BUTTON)
            queue_ack(CODE_NOT_UNDERSTOOD);
    endtask

    // Advance the predictor by one accepted request
    task automatic track_frame_byte(input logic [7:0] b, input logic eof);
        logic [7:0] closing_sum;
        if (seen_count < HEAD_LEN)
            head_copy[seen_count[HEAD_IW-1:0]] = b;
        // The sum runs one byte behind and never includes the first byte
        if (seen_count >= 2)
            byte_sum = byte_sum + last_byte;
        last_byte  = b;
        seen_count = seen_count + 1'b1;
        if (!eof && seen_count < FRAME_MAX)
            return;
        closing_sum = byte_sum;
        byte_sum    = '0;
        last_byte   = '0;
        seen_count  = '0;
        // Checksum is judged before the mark byte
        if (b != closing_sum)
            queue_ack(CODE_CHECKSUM);
        else if (head_copy[0] != MARK_BYTE)
            queue_ack(CODE_NOT_SUPPORTED);
        else
            decode_command();
    endtask

    // -----------------------------------------------------------------------
    // Request side
    // -----------------------------------------------------------------------

    // Offer one byte at the falling edge and hold it until an edge with full
    // low takes it; then idle for a random stretch unless in a steady run.
    task automatic send_byte(input logic [7:0] b, input logic eof);
        int gap;
        @(negedge clk);
        push         <= 1'b1;
        rx_byte      <= b;
        end_of_frame <= eof;
        do
            @(posedge clk);
        while (full);
        track_frame_byte(b, eof);
        requests_taken++;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Send bytes in order; flag the last one as frame end when asked
    task automatic send_frame(input byte_q_t bytes, input logic close);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], close && (i == bytes.size() - 1));
    endtask

    // Append the sum of every byte after the first
    function automatic byte_q_t seal(input byte_q_t body);
        byte_q_t    f;
        logic [7:0] s;
        s = '0;
        for (int i = 1; i < body.size(); i++)
            s = s + body[i];
        f = body;
        f.push_back(s);
        return f;
    endfunction

    // -----------------------------------------------------------------------
    // Reply side
    // -----------------------------------------------------------------------

    // Pop with random stalls, switching now and then to a stretch without any
    initial
    begin : reply_drain
        int   stall_left;
        int   phase_left;
        logic steady;
        pop        = 1'b0;
        stall_left = 0;
        phase_left = 0;
        steady     = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (phase_left == 0)
            begin
                steady     = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(50, 300);
            end
            else
                phase_left--;
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
                if (!steady)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic report_reply(input string what, input reply_t want, input reply_t seen);
        reply_errors++;
        if (reply_errors <= REPORT_LIMIT)
        begin
            $display("%0t %s: expected kind %0d tx %02h last %0d led %h",
                     $realtime, what, want.kind, want.tx, want.last, want.leds);
            $display("    got kind %0d tx %02h last %0d led %h",
                     seen.kind, seen.tx, seen.last, seen.leds);
        end
    endtask

    // Compare every reply taken by a pop against the oldest one predicted
    always @(posedge clk)
    begin : check_replies
        reply_t seen;
        reply_t want;
        if (rst_n && pop && !empty)
        begin
            seen.kind = out_kind;
            seen.tx   = tx_byte;
            seen.last = run_last;
            seen.leds = led_lit;
            if (awaited_replies.size() == 0)
                report_reply("unexpected reply", '0, seen);
            else
            begin
                want = awaited_replies.pop_front();
                if (seen.kind !== want.kind || seen.tx !== want.tx ||
                    seen.last !== want.last || seen.leds !== want.leds)
                    report_reply("reply mismatch", want, seen);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Light and darken LED 3, an out-of-range LED number, and a bad length
    task automatic test_led_control();
        byte_q_t f;
        f = '{MARK_BYTE, 8'h00, 8'h01, 8'h01, 8'h03};
        send_frame(seal(f), 1'b1);
        f = '{MARK_BYTE, 8'h00, 8'h02, 8'h01, 8'h03};
        send_frame(seal(f), 1'b1);
        f = '{MARK_BYTE, 8'h00, 8'h01, 8'h01, 8'hFF};
        send_frame(seal(f), 1'b1);
        f = '{MARK_BYTE, 8'h00, 8'h02, 8'h02, 8'h00};
        send_frame(seal(f), 1'b1);
    endtask

    // LCD and button commands: accepted, but no reply
    task automatic test_silent_commands();
        byte_q_t f;
        f = '{MARK_BYTE, 8'h00, 8'h03};
        send_frame(seal(f), 1'b1);
        f = '{MARK_BYTE, 8'h00, 8'h04};
        send_frame(seal(f), 1'b1);
    endtask

    // Unknown command, bad checksum, missing mark byte and the shortest frames
    task automatic test_rejected_frames();
        byte_q_t f;
        f = '{MARK_BYTE, 8'hFF, 8'hFF};
        send_frame(seal(f), 1'b1);
        f = '{MARK_BYTE, 8'h00, 8'h01, 8'h01, 8'h00, 8'h77};
        send_frame(f, 1'b1);
        // One-byte frames: the sum is zero, so 00 passes and FF fails
        send_byte(8'h00, 1'b1);
        send_byte(MARK_BYTE, 1'b1);
        f = '{8'h12};
        send_frame(seal(f), 1'b1);
    endtask

    // A frame with no end mark at all must close on its last allowed byte
    task automatic test_frame_limit();
        byte_q_t f;
        f = '{MARK_BYTE, 8'h00, 8'h01, 8'h01, 8'h02};
        while (f.size() < FRAME_MAX - 1)
            f.push_back(8'($urandom_range(0, 255)));
        send_frame(seal(f), 1'b0);
    endtask

    // Mostly well-formed frames with random content, plus broken frames and noise
    task automatic random_frame();
        byte_q_t    f;
        int         pick;
        int         n;
        logic [7:0] b;
        f    = {};
        pick = $urandom_range(0, 99);
        sender_steady = ($urandom_range(0, 4) == 0);
        if (pick < 45)
        begin
            f.push_back(MARK_BYTE);
            f.push_back(8'h00);
            f.push_back($urandom_range(0, 1) ? CMD_LED_ON[7:0] : CMD_LED_OFF[7:0]);
            f.push_back($urandom_range(0, 9) != 0 ? LED_LEN : 8'($urandom_range(0, 255)));
            f.push_back($urandom_range(0, 6) != 0 ? 8'($urandom_range(0, LED_COUNT - 1))
                                                  : 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 2)) f.push_back(8'($urandom_range(0, 255)));
            send_frame(seal(f), 1'b1);
        end
        else if (pick < 55)
        begin
            f.push_back(MARK_BYTE);
            f.push_back(8'h00);
            f.push_back($urandom_range(0, 1) ? CMD_LCD[7:0] : CMD_BUTTON[7:0]);
            repeat ($urandom_range(0, 6)) f.push_back(8'($urandom_range(0, 255)));
            send_frame(seal(f), 1'b1);
        end
        else if (pick < 65)
        begin
            f.push_back(MARK_BYTE);
            repeat ($urandom_range(2, 6)) f.push_back(8'($urandom_range(0, 255)));
            send_frame(seal(f), 1'b1);
        end
        else if (pick < 75)
        begin
            // Corrupt the checksum by a non-zero flip
            f.push_back(MARK_BYTE);
            repeat ($urandom_range(1, 6)) f.push_back(8'($urandom_range(0, 255)));
            f = seal(f);
            f[f.size() - 1] = f[f.size() - 1] ^ 8'($urandom_range(1, 255));
            send_frame(f, 1'b1);
        end
        else if (pick < 83)
        begin
            b = 8'($urandom_range(0, 254));
            f.push_back(b);
            repeat ($urandom_range(0, 6)) f.push_back(8'($urandom_range(0, 255)));
            send_frame(seal(f), 1'b1);
        end
        else if (pick < 93)
        begin
            // Short frames reuse head bytes left by earlier frames and acknowledges
            f.push_back($urandom_range(0, 1) ? MARK_BYTE : 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3)) f.push_back(8'($urandom_range(0, 255)));
            f = seal(f);
            f.pop_front();
            f.push_front(f.size() == 0 ? 8'h00 : MARK_BYTE);
            send_frame(seal(f[0:f.size() - 2]), 1'b1);
        end
        else
        begin
            // Noise with end marks anywhere, now and then a longer run
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)),
                          (i == n - 1) || ($urandom_range(0, 5) == 0));
        end
    endtask

    task automatic test_random_traffic();
        int stop_at;
        stop_at = requests_taken + RANDOM_ITEMS;
        while (requests_taken < stop_at)
            random_frame();
        sender_steady = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------

    initial
    begin
        int waited;
        rst_n          = 1'b0;
        push           = 1'b0;
        rx_byte        = 8'h00;
        end_of_frame   = 1'b0;
        reply_errors   = 0;
        requests_taken = 0;
        sender_steady  = 1'b0;
        clear_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_led_control();
        test_silent_commands();
        test_rejected_frames();
        test_frame_limit();
        test_random_traffic();

        // Drop the request line once the last byte is in
        @(negedge clk);
        push <= 1'b0;

        // Drain: every predicted reply must turn up
        waited = 0;
        while (awaited_replies.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (awaited_replies.size() != 0)
        begin
            reply_errors += awaited_replies.size();
            $display("%0d predicted replies never arrived", awaited_replies.size());
        end

        // Hold a little longer to catch any stray reply
        repeat (SETTLE_TIME) @(posedge clk);

        if (reply_errors == 0)
            $display("** led_command_frame_checker: PASSED **");
        else
            $display("** led_command_frame_checker: FAILED **");
        $finish;
    end

endmodule
